### src/sedf_pkg.sv
// sedf_pkg: shared constants, types and CRC function for the STX/ETX deframer.
// No dependencies; used by every module of the block.
package sedf_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int MEM_DEPTH   = 2 * MAX_PAYLOAD;

  localparam logic [7:0]  SYM_STX  = 8'h02;
  localparam logic [7:0]  SYM_ETX  = 8'h03;
  localparam logic [7:0]  SYM_DLE  = 8'h10;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(MAX_PAYLOAD);

  // store write from front to back
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // validated frame handed from front to back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
  } frame_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### src/sedf_front.sv
// sedf_front: line byte parser, CRC check and payload store writer.
// Depends on sedf_pkg; feeds sedf_queue and the store in sedf_back.
module sedf_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sedf_pkg::LEN_W-1:0]  cfg_data,
  input  logic [1:0]                  banks_owned,
  output sedf_pkg::wr_t               wr,
  output logic                        push,
  output sedf_pkg::frame_t            push_frame
);

  typedef enum logic [1:0] {PH_IDLE, PH_MSB, PH_LSB, PH_DATA} phase_t;

  phase_t                     phase;
  logic                       esc;
  logic [15:0]                carried;
  logic [15:0]                crc;
  logic [sedf_pkg::LEN_W-1:0] count;
  logic                       wbank;
  logic [sedf_pkg::LEN_W-1:0] limit;
  logic [sedf_pkg::LEN_W-1:0] lim_eff;
  logic                       accept;
  logic                       is_stx, is_etx, is_dle;

  assign cfg_ready = 1'b1;
  assign in_stall  = (banks_owned >= 2'd2);
  assign accept    = in_valid && !in_stall;
  assign lim_eff   = (limit > sedf_pkg::LEN_W'(sedf_pkg::MAX_PAYLOAD)) ?
                     sedf_pkg::LEN_W'(sedf_pkg::MAX_PAYLOAD) : limit;

  assign is_stx = !esc && (rx_byte == sedf_pkg::SYM_STX);
  assign is_etx = !esc && (rx_byte == sedf_pkg::SYM_ETX);
  assign is_dle = !esc && (rx_byte == sedf_pkg::SYM_DLE);

  always_comb begin
    wr.en   = accept && !is_stx && !is_etx && !is_dle && (phase == PH_DATA) &&
              (count < lim_eff);
    wr.addr = {wbank, count[sedf_pkg::IDX_W-1:0]};
    wr.data = rx_byte;
    push    = accept && is_etx && (phase == PH_DATA) && (crc == carried);
    push_frame.bank = wbank;
    push_frame.len  = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      esc     <= 1'b0;
      carried <= '0;
      crc     <= sedf_pkg::CRC_INIT;
      count   <= '0;
      wbank   <= 1'b0;
      limit   <= sedf_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (accept) begin
        if (is_stx) begin
          count <= '0;
          phase <= PH_MSB;
          crc   <= sedf_pkg::CRC_INIT;
        end else if (is_etx) begin
          if (phase == PH_DATA) begin
            phase <= PH_IDLE;
            if (push) begin
              wbank <= ~wbank;
            end
          end
        end else if (is_dle) begin
          esc <= 1'b1;
        end else begin
          esc <= 1'b0;
          case (phase)
            PH_MSB: begin
              carried <= {rx_byte, 8'h00};
              phase   <= PH_LSB;
            end
            PH_LSB: begin
              carried[7:0] <= rx_byte;
              phase        <= PH_DATA;
            end
            PH_DATA: begin
              if (count < lim_eff) begin
                count <= count + 1'b1;
                crc   <= sedf_pkg::crc_fold(crc, rx_byte);
              end else begin
                phase <= PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

endmodule

### src/sedf_queue.sv
// sedf_queue: two-entry queue of validated frames between front and back.
// Depends on sedf_pkg.
module sedf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sedf_pkg::frame_t push_frame,
  input  logic             pop,
  output sedf_pkg::frame_t head,
  output logic [1:0]       count
);

  sedf_pkg::frame_t slots [2];
  logic             wptr, rptr;

  assign head = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

### src/sedf_back.sv
// sedf_back: two-bank payload store and burst emitter with output register.
// Depends on sedf_pkg; reads frames from sedf_queue.
module sedf_back (
  input  logic                        clk,
  input  logic                        rst,
  input  sedf_pkg::wr_t               wr,
  input  logic [1:0]                  q_count,
  input  sedf_pkg::frame_t            q_head,
  output logic                        pop,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  payload_byte,
  output logic [sedf_pkg::LEN_W-1:0]  frame_length,
  output logic                        last_of_frame,
  output logic                        empty_frame
);

  logic [7:0] mem [sedf_pkg::MEM_DEPTH];

  logic                       bank;
  logic [sedf_pkg::LEN_W-1:0] len;
  logic [sedf_pkg::LEN_W-1:0] idx;
  logic                       s1_valid;
  logic [7:0]                 rd_data;
  logic [sedf_pkg::LEN_W-1:0] s1_len;
  logic                       s1_last;
  logic                       s1_empty;
  logic                       out_load;
  logic                       s1_free;
  logic                       issue;
  logic                       is_last;

  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign s1_free  = !s1_valid || out_load;
  assign issue    = busy && s1_free;
  assign pop      = !busy && (q_count != 2'd0);
  assign is_last  = (len == '0) || (idx == len - 1'b1);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      rd_data <= mem[{bank, idx[sedf_pkg::IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        bank <= q_head.bank;
        len  <= q_head.len;
        idx  <= '0;
      end else if (issue) begin
        idx <= idx + 1'b1;
        if (is_last) begin
          busy <= 1'b0;
        end
      end
      if (issue) begin
        s1_valid <= 1'b1;
        s1_len   <= len;
        s1_last  <= is_last;
        s1_empty <= (len == '0);
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid     <= 1'b1;
        payload_byte  <= s1_empty ? 8'h00 : rd_data;
        frame_length  <= s1_len;
        last_of_frame <= s1_last;
        empty_frame   <= s1_empty;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/stx_etx_deframer_crc16_unit.sv
// stx_etx_deframer_crc16_unit: top level of the DLE-escaped STX/ETX deframer
// with CRC-16/CCITT-FALSE check. Depends on sedf_pkg, sedf_front, sedf_queue
// and sedf_back.
//
// Usage:
//   Input: one line byte per transaction on rx_byte, taken when in_valid is
//   high and in_stall is low. Output: one transaction per payload byte of a
//   frame whose CRC matched, or one empty_frame transaction for a valid frame
//   without payload; taken when out_valid is high and out_stall is low.
//   cfg_valid/cfg_ready write payload_limit (reset 64, values above 64 act
//   as 64); write it only while the block is idle.
//   Throughput: one input byte per cycle while in_stall is low; one result
//   per cycle in a burst while out_stall is low. A closed frame passes the
//   queue, burst state, read and output registers. The store has two banks
//   of 64 bytes; in_stall rises while both banks hold frames not yet fully
//   read out, so input waits at most one frame burst behind the output.
//   A stalled receiver holds the output register; the pipeline behind it
//   fills, then the banks, then in_stall rises.
//   Reset (rst, synchronous) returns the parser to idle, clears the queue and
//   drops any pending results.
module stx_etx_deframer_crc16_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sedf_pkg::LEN_W-1:0]  cfg_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  payload_byte,
  output logic [sedf_pkg::LEN_W-1:0]  frame_length,
  output logic                        last_of_frame,
  output logic                        empty_frame
);

  sedf_pkg::wr_t    wr;
  logic             push;
  sedf_pkg::frame_t push_frame;
  logic             pop;
  sedf_pkg::frame_t q_head;
  logic [1:0]       q_count;
  logic             busy;
  logic [1:0]       banks_owned;

  assign banks_owned = q_count + {1'b0, busy};

  sedf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .banks_owned(banks_owned),
    .wr         (wr),
    .push       (push),
    .push_frame (push_frame)
  );

  sedf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_frame(push_frame),
    .pop       (pop),
    .head      (q_head),
    .count     (q_count)
  );

  sedf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .q_count      (q_count),
    .q_head       (q_head),
    .pop          (pop),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .last_of_frame(last_of_frame),
    .empty_frame  (empty_frame)
  );

endmodule

### test/stx_etx_deframer_crc16_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for stx_etx_deframer_crc16_unit: a directed table and then
// random framed traffic, with a local CRC-16 deframer predicting every output transaction.
// Depends on sedf_pkg and the RTL of the block only.
module stx_etx_deframer_crc16_unit_test;

  typedef enum logic [1:0] {PH_IDLE, PH_CRC_HI, PH_CRC_LO, PH_DATA} phase_e;

  typedef struct packed {
    logic [7:0]                 data;
    logic [sedf_pkg::LEN_W-1:0] len;
    logic                       last;
    logic                       empty;
  } beat_t;

  typedef struct packed {
    logic                       wr_limit;
    logic [sedf_pkg::LEN_W-1:0] limit;
    logic [7:0]                 b;
    logic                       typed;
    beat_t                      want;
  } plan_row_t;

  localparam beat_t NO_BEAT    = '{8'h00, 7'd0, 1'b0, 1'b0};
  localparam beat_t EMPTY_BEAT = '{8'h00, 7'd0, 1'b1, 1'b1};
  localparam int    PLAN_ROWS  = 31;
  localparam int    ITEM_GOAL  = 450;
  localparam int    PHASE_ITEMS = 60;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [7:0]                 rx_byte = 8'h00;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [sedf_pkg::LEN_W-1:0] cfg_data = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [7:0]                 payload_byte;
  logic [sedf_pkg::LEN_W-1:0] frame_length;
  logic                       last_of_frame;
  logic                       empty_frame;

  stx_etx_deframer_crc16_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .payload_byte(payload_byte), .frame_length(frame_length),
    .last_of_frame(last_of_frame), .empty_frame(empty_frame)
  );

  // predictor state
  logic [sedf_pkg::LEN_W-1:0] limit_reg = sedf_pkg::LIMIT_RESET;
  phase_e                     phase = PH_IDLE;
  logic                       esc = 1'b0;
  logic [15:0]                want_crc = 16'h0000;
  logic [15:0]                run_crc = sedf_pkg::CRC_INIT;
  int                         fill = 0;
  logic [7:0]                 store [sedf_pkg::MAX_PAYLOAD];

  beat_t beats_due[$];
  int    just_made;
  bit    just_ignored;
  int    counted = 0;
  int    faults = 0;
  bit    gaps_on = 1'b1;

  plan_row_t plan [0:PLAN_ROWS-1] = '{
    '{1'b1, 7'd127, 8'h10, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h02, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h29, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'hB1, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h31, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h32, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h33, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h34, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h35, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h36, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h37, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h38, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h39, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h02, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h10, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h02, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h10, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h10, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b0, NO_BEAT},
    '{1'b1, 7'd0,   8'h02, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'hFF, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'hFF, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b1, EMPTY_BEAT},
    '{1'b0, 7'd0,   8'h02, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'hFF, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'hFF, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h00, 1'b0, NO_BEAT},
    '{1'b0, 7'd0,   8'h03, 1'b0, NO_BEAT}
  };

  logic [sedf_pkg::LEN_W-1:0] limit_plan [0:7] =
    '{7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd2, 7'd100, 7'd64};

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0};
      if (fb) c = c ^ sedf_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic bit is_special(input logic [7:0] b);
    return b == sedf_pkg::SYM_STX || b == sedf_pkg::SYM_ETX || b == sedf_pkg::SYM_DLE;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int cap;
    cap = (limit_reg > sedf_pkg::MAX_PAYLOAD) ? sedf_pkg::MAX_PAYLOAD : limit_reg;
    just_made = 0;
    just_ignored = 1'b0;
    if (!esc && b == sedf_pkg::SYM_STX) begin
      fill = 0;
      phase = PH_CRC_HI;
      run_crc = sedf_pkg::CRC_INIT;
    end else if (!esc && b == sedf_pkg::SYM_ETX) begin
      if (phase == PH_DATA) begin
        if (run_crc == want_crc) begin
          if (fill == 0) begin
            beats_due.push_back(EMPTY_BEAT);
            just_made = 1;
          end else begin
            for (int k = 0; k < fill; k++) begin
              beats_due.push_back('{store[k], sedf_pkg::LEN_W'(fill), k == fill - 1, 1'b0});
            end
            just_made = fill;
          end
        end
        phase = PH_IDLE;
      end else begin
        just_ignored = 1'b1;
      end
    end else if (!esc && b == sedf_pkg::SYM_DLE) begin
      esc = 1'b1;
    end else begin
      esc = 1'b0;
      case (phase)
        PH_IDLE: begin
          just_ignored = 1'b1;
        end
        PH_CRC_HI: begin
          want_crc = {b, 8'h00};
          phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          want_crc[7:0] = b;
          phase = PH_DATA;
        end
        PH_DATA: begin
          if (fill < cap) begin
            store[fill] = b;
            fill++;
            run_crc = crc16_step(run_crc, b);
          end else begin
            phase = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  endtask

  // leaves in_valid high after acceptance so back-to-back transactions need no re-raise
  task automatic put_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(b);
    if (!just_ignored) counted++;
  endtask

  task automatic put_lit(input logic [7:0] b);
    if (is_special(b)) put_byte(sedf_pkg::SYM_DLE);
    put_byte(b);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_limit(input logic [sedf_pkg::LEN_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_reg = v;
  endtask

  task automatic send_frame(input int len, input bit bad_crc, input bit close);
    logic [7:0]  body[$];
    logic [7:0]  v;
    logic [15:0] c;
    c = sedf_pkg::CRC_INIT;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 20) begin
        case ($urandom_range(2))
          0: v = sedf_pkg::SYM_STX;
          1: v = sedf_pkg::SYM_ETX;
          default: v = sedf_pkg::SYM_DLE;
        endcase
      end else begin
        v = 8'($urandom_range(255));
      end
      body.push_back(v);
      c = crc16_step(c, v);
    end
    if (bad_crc) c = c ^ (16'h0001 << $urandom_range(15));
    put_byte(sedf_pkg::SYM_STX);
    put_lit(c[15:8]);
    put_lit(c[7:0]);
    foreach (body[i]) put_lit(body[i]);
    if (close) put_byte(sedf_pkg::SYM_ETX);
  endtask

  task automatic check_beat;
    beat_t want;
    if (beats_due.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("unexpected transaction: byte %h len %0d last %b empty %b",
                 payload_byte, frame_length, last_of_frame, empty_frame);
      return;
    end
    want = beats_due.pop_front();
    if (payload_byte !== want.data || frame_length !== want.len ||
        last_of_frame !== want.last || empty_frame !== want.empty) begin
      faults++;
      if (faults <= 10)
        $display("mismatch: exp byte %h len %0d last %b empty %b, got %h %0d %b %b",
                 want.data, want.len, want.last, want.empty,
                 payload_byte, frame_length, last_of_frame, empty_frame);
    end
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) check_beat();
      out_stall <= gaps_on && ($urandom_range(99) < 11);
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int cap;
    int len;
    int pick;
    int goal;
    logic [sedf_pkg::LEN_W-1:0] lim;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < PLAN_ROWS; r++) begin
      if (plan[r].wr_limit) set_limit(plan[r].limit);
      put_byte(plan[r].b);
      if (plan[r].typed) begin
        repeat (just_made) void'(beats_due.pop_back());
        beats_due.push_back(plan[r].want);
      end
    end

    for (int p = 0; counted < ITEM_GOAL; p++) begin
      lim = (p < 8) ? limit_plan[p] : sedf_pkg::LEN_W'($urandom_range(127));
      set_limit(lim);
      gaps_on = (p != 2);
      cap = (lim > sedf_pkg::MAX_PAYLOAD) ? sedf_pkg::MAX_PAYLOAD : lim;
      goal = counted + PHASE_ITEMS;
      while (counted < goal) begin
        pick = $urandom_range(99);
        len = $urandom_range(99);
        if (len < 80) len = $urandom_range(cap < 6 ? cap : 6);
        else if (len < 95) len = $urandom_range(cap);
        else len = cap + 1;
        if (pick < 75) begin
          send_frame(len, 1'b0, 1'b1);
        end else if (pick < 85) begin
          send_frame(len, 1'b1, 1'b1);
        end else if (pick < 92) begin
          send_frame(len, 1'b0, 1'b0);
        end else begin
          repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
        end
      end
    end
    gaps_on = 1'b1;

    drain();
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
